/* rtl/kcqv_pkg.sv */
package kcqv_pkg;

   localparam int KEY_MAX_DEF = 32;

   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_LOWER_T    = 8'h74;

   typedef enum logic [3:0] {
      MODE_SKIPWS    = 4'd0,
      MODE_SKIPLINE  = 4'd1,
      MODE_KEY       = 4'd2,
      MODE_PRECOLON  = 4'd3,
      MODE_POSTCOLON = 4'd4,
      MODE_VALUE     = 4'd5,
      MODE_ESC       = 4'd6,
      MODE_ESC_CR    = 4'd7
   } kcqv_mode_type;

   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_END    = 2'd2,
      KIND_UNTERM = 2'd3
   } kcqv_kind_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_READ,
      CTRL_KEY,
      CTRL_UNTERM
   } kcqv_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic key_emit;
      logic unterm_emit;
   } kcqv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic drain;
      logic unterm_pending;
      logic drain_last;
   } kcqv_sts_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_keych(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDERSCORE);
   endfunction

endpackage

/* rtl/key_colon_quoted_value_scanner_core.sv */
// key_colon_quoted_value_scanner_core
// scans a text stream for lines "identifier [blanks] : [blanks] "value""
// and returns the key bytes, the unescaped value bytes and an entry end
// req channel: one raw byte per word (req_in_byte), req_end_of_input marks
//   the last byte of a buffer and resets the scanner after that byte
// rsp channel: kind (key byte, value byte, entry end, unterminated value),
//   out_byte, run_last on the final word caused by one req word, and
//   key_truncated on key bytes of a key longer than KEY_MAX
// timing: a result is loaded at the edge that takes the req word and is
//   offered from the next cycle; each key byte of a drain is read from the
//   key ram in a read state and loaded into the output in the key state
// sequencing: a word with zero or one result is taken from the idle state;
//   a second result (value byte then unterminated) is loaded from an extra
//   unterm state; the opening quote drains the key from the key ram, a ram
//   read state plus an output load per key byte, before the next word is taken
// the block handles one req word at a time; req_stall is high while a key
//   drain or second result is pending or while the output register is full
//   and rsp_stall is high
// stall: a stalled rsp word holds in the output register; the next word
//   loads in the same cycle the current one is taken
// reset: synchronous, returns to blank skipping with an empty key; the key
//   ram needs no clearing, only written entries are ever read
module key_colon_quoted_value_scanner_core #(
   parameter int KEY_MAX = kcqv_pkg::KEY_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_key_truncated
);

   // command and status between controller and datapath
   kcqv_pkg::kcqv_cmd_type cmd;
   kcqv_pkg::kcqv_sts_type sts;

   // sequencing: accept, key drain, trailing unterminated word
   kcqv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // scan state, key ram and output register
   kcqv_dp #(
      .KEY_MAX (KEY_MAX)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_in_byte       (req_in_byte),
      .req_end_of_input  (req_end_of_input),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_key_truncated (rsp_key_truncated),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

/* rtl/kcqv_ram.sv */
module kcqv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kcqv_ctrl.sv */
module kcqv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kcqv_pkg::kcqv_sts_type sts,
   output kcqv_pkg::kcqv_cmd_type cmd
);

   kcqv_pkg::kcqv_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcqv_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         kcqv_pkg::CTRL_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.take = 1'b1;
               if (sts.drain) begin
                  state_in = kcqv_pkg::CTRL_READ;
               end else if (sts.unterm_pending) begin
                  state_in = kcqv_pkg::CTRL_UNTERM;
               end
            end
         end
         // ram address settles, data registered next cycle
         kcqv_pkg::CTRL_READ: begin
            state_in = kcqv_pkg::CTRL_KEY;
         end
         kcqv_pkg::CTRL_KEY: begin
            if (sts.out_free) begin
               cmd.key_emit = 1'b1;
               state_in = sts.drain_last ? kcqv_pkg::CTRL_IDLE : kcqv_pkg::CTRL_READ;
            end
         end
         kcqv_pkg::CTRL_UNTERM: begin
            if (sts.out_free) begin
               cmd.unterm_emit = 1'b1;
               state_in = kcqv_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = kcqv_pkg::CTRL_IDLE;
         end
      endcase
   end

   a_read_then_key: assert property (@(posedge clock) disable iff (reset)
      state_ff == kcqv_pkg::CTRL_READ |=> state_ff == kcqv_pkg::CTRL_KEY)
      else $error("read state not followed by key state");

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.take && sts.drain |=> state_ff == kcqv_pkg::CTRL_READ)
      else $error("opening quote did not start key drain");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.key_emit, cmd.unterm_emit}))
      else $error("conflicting datapath commands");

endmodule

/* rtl/kcqv_dp.sv */
module kcqv_dp #(
   parameter int KEY_MAX = kcqv_pkg::KEY_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_end_of_input,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_key_truncated,
   input  kcqv_pkg::kcqv_cmd_type cmd,
   output kcqv_pkg::kcqv_sts_type sts
);

   localparam int ADDR_W = $clog2(KEY_MAX);
   localparam int LEN_W  = $clog2(KEY_MAX + 1);

   kcqv_pkg::kcqv_mode_type mode_ff, mode_in, mode_nx;
   logic [LEN_W-1:0]        len_ff, len_in, len_nx;
   logic                    ovf_ff, ovf_in, ovf_nx;
   logic [LEN_W-1:0]        idx_ff, idx_in, idx_inc;

   logic                    rsp_valid_ff, rsp_valid_in;
   kcqv_pkg::kcqv_kind_type kind_ff, kind_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic                    trunc_ff, trunc_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [7:0]              rd_data;

   logic                    e_valid;
   kcqv_pkg::kcqv_kind_type e_kind;
   logic [7:0]              e_byte;
   logic                    vb;
   logic                    quote_open;
   logic                    unterm;
   logic                    out_free;

   // only a taken word writes the key buffer
   kcqv_ram #(
      .WIDTH (8),
      .DEPTH (KEY_MAX)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en && cmd.take),
      .wr_addr (wr_addr),
      .wr_data (req_in_byte),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // scanner step for one input byte
   always_comb begin
      mode_nx    = mode_ff;
      len_nx     = len_ff;
      ovf_nx     = ovf_ff;
      wr_en      = 1'b0;
      wr_addr    = len_ff[ADDR_W-1:0];
      e_valid    = 1'b0;
      e_kind     = kcqv_pkg::KIND_VALUE;
      e_byte     = req_in_byte;
      vb         = 1'b0;
      quote_open = 1'b0;
      unique case (mode_ff)
         kcqv_pkg::MODE_SKIPLINE: begin
            if (kcqv_pkg::is_eol(req_in_byte)) begin
               mode_nx = kcqv_pkg::MODE_SKIPWS;
            end
         end
         kcqv_pkg::MODE_KEY: begin
            if (kcqv_pkg::is_keych(req_in_byte)) begin
               if (len_ff < LEN_W'(KEY_MAX)) begin
                  wr_en  = 1'b1;
                  len_nx = len_ff + LEN_W'(1);
               end else begin
                  ovf_nx = 1'b1;
               end
            end else if (kcqv_pkg::is_blank(req_in_byte)) begin
               mode_nx = kcqv_pkg::is_eol(req_in_byte) ? kcqv_pkg::MODE_SKIPWS
                                                       : kcqv_pkg::MODE_PRECOLON;
            end else begin
               mode_nx = (req_in_byte == kcqv_pkg::CH_COLON) ? kcqv_pkg::MODE_POSTCOLON
                                                             : kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_PRECOLON: begin
            if (kcqv_pkg::is_blank(req_in_byte)) begin
               if (kcqv_pkg::is_eol(req_in_byte)) begin
                  mode_nx = kcqv_pkg::MODE_SKIPWS;
               end
            end else begin
               mode_nx = (req_in_byte == kcqv_pkg::CH_COLON) ? kcqv_pkg::MODE_POSTCOLON
                                                             : kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_POSTCOLON: begin
            if (kcqv_pkg::is_blank(req_in_byte)) begin
               if (kcqv_pkg::is_eol(req_in_byte)) begin
                  mode_nx = kcqv_pkg::MODE_SKIPWS;
               end
            end else if (req_in_byte == kcqv_pkg::CH_QUOTE) begin
               quote_open = 1'b1;
               mode_nx    = kcqv_pkg::MODE_VALUE;
            end else begin
               mode_nx = kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_VALUE: begin
            vb = 1'b1;
         end
         kcqv_pkg::MODE_ESC: begin
            mode_nx = kcqv_pkg::MODE_VALUE;
            if (req_in_byte == kcqv_pkg::CH_CR) begin
               mode_nx = kcqv_pkg::MODE_ESC_CR;
            end else if (req_in_byte == kcqv_pkg::CH_LOWER_T) begin
               e_valid = 1'b1;
               e_byte  = kcqv_pkg::CH_TAB;
            end else if (req_in_byte != kcqv_pkg::CH_LF) begin
               e_valid = 1'b1;
            end
         end
         kcqv_pkg::MODE_ESC_CR: begin
            mode_nx = kcqv_pkg::MODE_VALUE;
            vb      = (req_in_byte != kcqv_pkg::CH_LF);
         end
         default: begin
            if (kcqv_pkg::is_blank(req_in_byte)) begin
               mode_nx = kcqv_pkg::MODE_SKIPWS;
            end else if (kcqv_pkg::is_alpha(req_in_byte)) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               len_nx  = LEN_W'(1);
               ovf_nx  = 1'b0;
               mode_nx = kcqv_pkg::MODE_KEY;
            end else begin
               mode_nx = kcqv_pkg::MODE_SKIPLINE;
            end
         end
      endcase
      // plain value byte handling
      if (vb) begin
         if (req_in_byte == kcqv_pkg::CH_BACKSLASH) begin
            mode_nx = kcqv_pkg::MODE_ESC;
         end else if (req_in_byte == kcqv_pkg::CH_QUOTE) begin
            e_valid = 1'b1;
            e_kind  = kcqv_pkg::KIND_END;
            e_byte  = '0;
            mode_nx = kcqv_pkg::MODE_SKIPLINE;
         end else begin
            e_valid = 1'b1;
         end
      end
   end

   assign unterm = req_end_of_input && (mode_nx == kcqv_pkg::MODE_VALUE ||
                                        mode_nx == kcqv_pkg::MODE_ESC ||
                                        mode_nx == kcqv_pkg::MODE_ESC_CR);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_inc  = idx_ff + LEN_W'(1);

   assign sts.out_free       = out_free;
   assign sts.drain          = quote_open && !req_end_of_input;
   assign sts.unterm_pending = e_valid && unterm;
   assign sts.drain_last     = (idx_inc == len_ff);

   // scan state and key registers
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      if (cmd.take) begin
         mode_in = mode_nx;
         len_in  = len_nx;
         ovf_in  = ovf_nx;
         if (req_end_of_input) begin
            mode_in = kcqv_pkg::MODE_SKIPWS;
            len_in  = '0;
            ovf_in  = 1'b0;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.take) begin
         idx_in = '0;
      end else if (cmd.key_emit) begin
         idx_in = idx_inc;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      trunc_in     = trunc_ff;
      if (cmd.take && (e_valid || unterm)) begin
         rsp_valid_in = 1'b1;
         kind_in      = e_valid ? e_kind : kcqv_pkg::KIND_UNTERM;
         byte_in      = e_valid ? e_byte : 8'h00;
         last_in      = !(e_valid && unterm);
         trunc_in     = 1'b0;
      end else if (cmd.key_emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = kcqv_pkg::KIND_KEY;
         byte_in      = rd_data;
         last_in      = sts.drain_last;
         trunc_in     = ovf_ff;
      end else if (cmd.unterm_emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = kcqv_pkg::KIND_UNTERM;
         byte_in      = 8'h00;
         last_in      = 1'b1;
         trunc_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= kcqv_pkg::MODE_SKIPWS;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      trunc_ff <= trunc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_run_last      = last_ff;
   assign rsp_key_truncated = trunc_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(KEY_MAX))
      else $error("key length beyond buffer");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> len_ff == LEN_W'(KEY_MAX))
      else $error("key overflow flagged with room left");

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.key_emit |-> idx_ff < len_ff)
      else $error("key drain read past buffered length");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int KEY_LIMIT    = kcqv_pkg::KEY_MAX_DEF;
   localparam int IDLE_LIMIT   = 1000;   // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 20;     // quiet cycles after the last expected word
   localparam int RANDOM_BYTES = 12;
   localparam int PRINT_LIMIT  = 200;

   // one byte of the input stream, as it goes onto the req side
   typedef struct {
      logic [7:0] data;
      logic       eoi;
   } feed_word_type;

   // one word expected on the rsp side
   typedef struct {
      kcqv_pkg::kcqv_kind_type kind;
      logic [7:0]              data;
      logic                    run_last;
      logic                    trunc;
   } result_word_type;

   logic       clock;
   logic       reset;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_key_truncated;

   feed_word_type   byte_feed[$];      // bytes not yet offered to the block
   result_word_type awaited_words[$];  // expected rsp words, oldest first
   logic [7:0]      line_bytes[$];     // scratch line for the random part

   // scanner state as the testbench sees it
   kcqv_pkg::kcqv_mode_type mode_now;
   logic [7:0]              key_chars [KEY_LIMIT];
   int                      key_count;
   logic                    key_cut;
   int                      word_results;

   int  mismatch_count = 0;
   int  bytes_taken    = 0;
   int  idle_cycles    = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   bit  send_quiet     = 1'b0;
   bit  recv_quiet     = 1'b0;
   int  total_bytes;
   int  random_bytes;

   key_colon_quoted_value_scanner_core #(
      .KEY_MAX(KEY_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_key_truncated(rsp_key_truncated)
   );

   // clock and a single reset at the start
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // character classes, C locale
   // ---------------------------------------------------------------------
   function automatic bit blank_char(input logic [7:0] c);
      return c == kcqv_pkg::CH_SPACE || (c >= kcqv_pkg::CH_TAB && c <= kcqv_pkg::CH_CR);
   endfunction

   function automatic bit line_break(input logic [7:0] c);
      return c == kcqv_pkg::CH_LF || c == kcqv_pkg::CH_CR;
   endfunction

   function automatic bit letter_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic bit ident_char(input logic [7:0] c);
      return letter_char(c) || (c >= 8'h30 && c <= 8'h39) || c == kcqv_pkg::CH_UNDERSCORE;
   endfunction

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   task automatic expect_word(input kcqv_pkg::kcqv_kind_type kind, input logic [7:0] data,
                              input logic trunc);
      result_word_type w;
      w.kind     = kind;
      w.data     = data;
      w.run_last = 1'b0;
      w.trunc    = trunc;
      awaited_words.push_back(w);
      word_results++;
   endtask

   // plain byte inside the quotes: escape start, closing quote or data
   task automatic take_value(input logic [7:0] c);
      if (c == kcqv_pkg::CH_BACKSLASH) begin
         mode_now = kcqv_pkg::MODE_ESC;
      end else if (c == kcqv_pkg::CH_QUOTE) begin
         expect_word(kcqv_pkg::KIND_END, 8'h00, 1'b0);
         mode_now = kcqv_pkg::MODE_SKIPLINE;
      end else begin
         expect_word(kcqv_pkg::KIND_VALUE, c, 1'b0);
      end
   endtask

   // steps the scanner by one accepted byte and queues the words it causes
   task automatic scan_byte(input logic [7:0] c, input logic eoi);
      result_word_type tail;
      word_results = 0;
      case (mode_now)
         kcqv_pkg::MODE_SKIPLINE: begin
            if (line_break(c)) mode_now = kcqv_pkg::MODE_SKIPWS;
         end
         kcqv_pkg::MODE_KEY: begin
            if (ident_char(c)) begin
               if (key_count < KEY_LIMIT) begin
                  key_chars[key_count] = c;
                  key_count++;
               end else begin
                  key_cut = 1'b1;
               end
            end else if (blank_char(c)) begin
               mode_now = line_break(c) ? kcqv_pkg::MODE_SKIPWS : kcqv_pkg::MODE_PRECOLON;
            end else begin
               mode_now = (c == kcqv_pkg::CH_COLON) ? kcqv_pkg::MODE_POSTCOLON
                                                    : kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_PRECOLON: begin
            if (blank_char(c)) begin
               if (line_break(c)) mode_now = kcqv_pkg::MODE_SKIPWS;
            end else begin
               mode_now = (c == kcqv_pkg::CH_COLON) ? kcqv_pkg::MODE_POSTCOLON
                                                    : kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_POSTCOLON: begin
            if (blank_char(c)) begin
               if (line_break(c)) mode_now = kcqv_pkg::MODE_SKIPWS;
            end else if (c == kcqv_pkg::CH_QUOTE) begin
               // a quote that is also the last byte drops the key
               if (!eoi) begin
                  for (int i = 0; i < key_count; i++)
                     expect_word(kcqv_pkg::KIND_KEY, key_chars[i], key_cut);
               end
               mode_now = kcqv_pkg::MODE_VALUE;
            end else begin
               mode_now = kcqv_pkg::MODE_SKIPLINE;
            end
         end
         kcqv_pkg::MODE_VALUE: begin
            take_value(c);
         end
         kcqv_pkg::MODE_ESC: begin
            mode_now = kcqv_pkg::MODE_VALUE;
            if (c == kcqv_pkg::CH_CR) begin
               mode_now = kcqv_pkg::MODE_ESC_CR;
            end else if (c == kcqv_pkg::CH_LOWER_T) begin
               expect_word(kcqv_pkg::KIND_VALUE, kcqv_pkg::CH_TAB, 1'b0);
            end else if (c != kcqv_pkg::CH_LF) begin
               expect_word(kcqv_pkg::KIND_VALUE, c, 1'b0);
            end
         end
         kcqv_pkg::MODE_ESC_CR: begin
            // backslash-cr-lf continues the line, anything else is a plain byte
            mode_now = kcqv_pkg::MODE_VALUE;
            if (c != kcqv_pkg::CH_LF) take_value(c);
         end
         default: begin
            if (blank_char(c)) begin
               mode_now = kcqv_pkg::MODE_SKIPWS;
            end else if (letter_char(c)) begin
               key_chars[0] = c;
               key_count    = 1;
               key_cut      = 1'b0;
               mode_now     = kcqv_pkg::MODE_KEY;
            end else begin
               mode_now = kcqv_pkg::MODE_SKIPLINE;
            end
         end
      endcase

      // end of buffer: flag an open value, then back to the reset state
      if (eoi) begin
         if (mode_now == kcqv_pkg::MODE_VALUE || mode_now == kcqv_pkg::MODE_ESC ||
             mode_now == kcqv_pkg::MODE_ESC_CR)
            expect_word(kcqv_pkg::KIND_UNTERM, 8'h00, 1'b0);
         mode_now  = kcqv_pkg::MODE_SKIPWS;
         key_count = 0;
         key_cut   = 1'b0;
      end

      if (word_results > 0) begin
         tail = awaited_words.pop_back();
         tail.run_last = 1'b1;
         awaited_words.push_back(tail);
      end
   endtask

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what, input int want, input int got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h",
                  $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_word();
      result_word_type want;
      if (awaited_words.size() == 0) begin
         note_mismatch("word with nothing expected", 0, int'({rsp_kind, rsp_out_byte}));
      end else begin
         want = awaited_words.pop_front();
         if (rsp_kind !== want.kind)          note_mismatch("kind", want.kind, rsp_kind);
         if (rsp_out_byte !== want.data)      note_mismatch("out_byte", want.data, rsp_out_byte);
         if (rsp_run_last !== want.run_last)  note_mismatch("run_last", want.run_last, rsp_run_last);
         if (rsp_key_truncated !== want.trunc)
            note_mismatch("key_truncated", want.trunc, rsp_key_truncated);
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] c, input logic eoi);
      feed_word_type w;
      w.data = c;
      w.eoi  = eoi;
      byte_feed.push_back(w);
   endtask

   // eoi_last marks the final character as the end of the buffer
   task automatic push_text(input string s, input bit eoi_last);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], eoi_last && i == s.len() - 1);
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] key_char(input bit first);
      int r;
      r = first ? $urandom_range(0, 51) : $urandom_range(0, 62);
      if (r < 26) return 8'(8'h41 + r);
      if (r < 52) return 8'(8'h61 + r - 26);
      if (r < 62) return 8'(8'h30 + r - 52);
      return kcqv_pkg::CH_UNDERSCORE;
   endfunction

   // blanks that do not end the line
   function automatic logic [7:0] inline_blank();
      case ($urandom_range(0, 3))
         0:       return kcqv_pkg::CH_SPACE;
         1:       return kcqv_pkg::CH_TAB;
         2:       return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   task automatic push_key(input int len);
      for (int i = 0; i < len; i++) push_byte(key_char(i == 0), 1'b0);
   endtask

   // one well formed entry line with random content into line_bytes
   task automatic build_entry();
      int klen;
      int vlen;
      line_bytes.delete();
      klen = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      for (int i = 0; i < klen; i++) line_bytes.push_back(key_char(i == 0));
      repeat ($urandom_range(0, 2)) line_bytes.push_back(inline_blank());
      line_bytes.push_back(kcqv_pkg::CH_COLON);
      repeat ($urandom_range(0, 2)) line_bytes.push_back(inline_blank());
      line_bytes.push_back(kcqv_pkg::CH_QUOTE);
      vlen = $urandom_range(0, 8);
      for (int i = 0; i < vlen; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            line_bytes.push_back(kcqv_pkg::CH_BACKSLASH);
            case ($urandom_range(0, 4))
               0: line_bytes.push_back(kcqv_pkg::CH_LOWER_T);
               1: line_bytes.push_back(kcqv_pkg::CH_LF);
               2: begin
                  line_bytes.push_back(kcqv_pkg::CH_CR);
                  line_bytes.push_back(kcqv_pkg::CH_LF);
               end
               3: begin
                  line_bytes.push_back(kcqv_pkg::CH_CR);
                  line_bytes.push_back(any_byte());
               end
               default: line_bytes.push_back(any_byte());
            endcase
         end else begin
            line_bytes.push_back(any_byte());
         end
      end
      line_bytes.push_back(kcqv_pkg::CH_QUOTE);
      // trailing junk after the closing quote is skipped
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) line_bytes.push_back(any_byte());
      case ($urandom_range(0, 2))
         0: line_bytes.push_back(kcqv_pkg::CH_LF);
         1: begin
            line_bytes.push_back(kcqv_pkg::CH_CR);
            line_bytes.push_back(kcqv_pkg::CH_LF);
         end
         default: line_bytes.push_back(kcqv_pkg::CH_CR);
      endcase
   endtask

   task automatic add_random_line();
      int style;
      int cut;
      style = $urandom_range(0, 19);
      if (style >= 18) begin
         // noise line, mostly ignored by the block
         repeat ($urandom_range(1, 8)) push_byte(any_byte(), 1'b0);
         push_byte(kcqv_pkg::CH_LF, $urandom_range(0, 3) == 0);
      end else begin
         build_entry();
         if (style >= 14 && style <= 15)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = any_byte();
         cut = line_bytes.size();
         if (style >= 16) cut = $urandom_range(1, line_bytes.size());
         for (int i = 0; i < cut; i++)
            push_byte(line_bytes[i],
                      i == cut - 1 && (style >= 16 || $urandom_range(0, 9) == 0));
         random_bytes += cut;
      end
   endtask

   task automatic add_directed();
      // escapes: tab, other byte, backslash, quote, lf and cr-lf continuation,
      // cr followed by a plain byte
      push_text("e:\"\\t\\q\\\\\\\"\\\nz\\\015\nw\\\015y\"\n", 1'b0);
      // cr after backslash then quote, and then backslash
      push_text("f:\"\\\015\"\n", 1'b0);
      push_text("g:\"\\\015\\t\"\n", 1'b0);
      // newline in the blanks restarts the search
      push_text("a \nb:\"1\"\n", 1'b0);
      push_text("c:\015\"x\"\n", 1'b0);
      // lines that do not start with a letter or break the pattern
      push_text("1:\n_:\nd-\nh:x\n", 1'b0);
      // blanks around the colon, raw tab in the value, rest of the line
      // after an entry is skipped, empty value
      push_text("a \t: \t\"x\ty\" b:\"y\"\nc:\"\"\015\n", 1'b0);
      // key one byte over the buffer size: full buffer, then truncated
      push_key(KEY_LIMIT + 1);
      push_text(":\"v\"\n", 1'b0);
      // byte extremes as line start and as value bytes
      push_byte(8'h00, 1'b0);
      push_byte(kcqv_pkg::CH_LF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(kcqv_pkg::CH_LF, 1'b0);
      push_text("v:\"", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_text("\"\n", 1'b0);
      // end of buffer inside a value, after backslash, after backslash-cr
      push_text("m:\"xy", 1'b1);
      push_text("n:\"\\", 1'b1);
      push_text("p:\"\\\015", 1'b1);
      // opening quote as the last byte gives only the unterminated word
      push_text("q :\"", 1'b1);
      // end of buffer in the key drops it
      push_text("abc", 1'b1);
      push_text(":\"x\"\n", 1'b0);
      // end of buffer on the closing quote
      push_text("r:\"x\"", 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // idle patterns
   // ---------------------------------------------------------------------
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------------
   // req driver: offers the feed, predicts on every accepted word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      feed_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         mode_now   = kcqv_pkg::MODE_SKIPWS;
         key_count  = 0;
         key_cut    = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            scan_byte(req_in_byte, req_end_of_input);
            bytes_taken++;
         end
         // slot free: either idle or the current word just went in
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
               w = byte_feed.pop_front();
               req_valid        <= 1'b1;
               req_in_byte      <= w.data;
               req_end_of_input <= w.eoi;
               gap_left = pick_gap(send_quiet);
               if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: random stall, compare against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_word();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(recv_quiet) : 0;
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 59) == 0) recv_quiet = !recv_quiet;
      end
   end

   // watchdog: nothing moving for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      random_bytes = 0;
      add_directed();
      while (random_bytes < RANDOM_BYTES) add_random_line();
      total_bytes = byte_feed.size();

      while (bytes_taken < total_bytes) @(posedge clock);
      while (awaited_words.size() > 0) @(posedge clock);
      // let any late extra word show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
